// File: rtl/two_region_binned_mean_heatmap_assert.svh
// Assertion macros for the binned mean heatmap block
`ifndef TWO_REGION_BINNED_MEAN_HEATMAP_ASSERT_SVH
`define TWO_REGION_BINNED_MEAN_HEATMAP_ASSERT_SVH
// implication checked every clock outside reset
`define TRBMH_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// next-cycle implication
`define TRBMH_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// File: rtl/trbmh_pkg.sv
// Package: shared types and constants of the binned mean heatmap
package trbmh_pkg;
    // grid size: time bins by levels, fixed by the 6-bit bin and level fields
    localparam int BIN_COUNT = 64;
    localparam int LEVELS    = 64;

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_LATE = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    localparam logic [2:0] CFG_SPLIT_TIME = 3'd0;
    localparam logic [2:0] CFG_END_TIME   = 3'd1;
    localparam logic [2:0] CFG_WIDTH1     = 3'd2;
    localparam logic [2:0] CFG_WIDTH2     = 3'd3;
    localparam logic [2:0] CFG_SPLIT_BIN  = 3'd4;
    localparam logic [2:0] CFG_BINS_USED  = 3'd5;
    localparam logic [2:0] CFG_LEVEL_MAX  = 3'd6;

    typedef struct packed {
        logic        req_type;
        logic [31:0] sample_time;
        logic [5:0]  level;
        logic [15:0] abundance;
        logic [5:0]  read_bin;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] mean_value;
        logic [15:0] cell_count;
        logic [31:0] bin_edge;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_word;

    // divider handshake between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage

// File: rtl/trbmh_if.sv
// Valid/ready channel interfaces for words and configuration
interface trbmh_in_if;
    import trbmh_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trbmh_out_if;
    import trbmh_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trbmh_cfg_if;
    import trbmh_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/trbmh_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
module trbmh_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trbmh_pkg::t_div_req i_req,
    output trbmh_pkg::t_div_rsp o_rsp
);
    import trbmh_pkg::*;

    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    // shift one dividend bit into the remainder and try subtract
    always_comb begin
        w_trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial[32]) begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end else begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// File: rtl/trbmh_cell_mem.sv
// Cell store: sum and count per cell, registered synchronous read
module trbmh_cell_mem #(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [31:0]       i_wsum,
    input  logic [15:0]       i_wcnt,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [31:0]       o_rsum,
    output logic [15:0]       o_rcnt
);
    logic [47:0] r_mem [2**ADDR_W];
    logic [47:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wsum, i_wcnt};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rsum = r_rdata[47:16];
    assign o_rcnt = r_rdata[15:0];
endmodule

// File: rtl/two_region_binned_mean_heatmap.sv
// Binned mean heatmap: accumulates samples per (time bin, level) cell and
// reads back the cell mean. One word at a time: an accumulate inside the grid
// runs a serial bin division, a cell check and a read-modify-write before its
// output (an accumulate outside the grid skips the write, a late sample goes
// straight to output); a read runs a mean division when the cell holds samples
// and skips it when the cell is empty or outside the grid. A result still
// waiting on the output adds its wait. After reset a clearing pass zeroes
// the cell store; no word is accepted during it, configuration writes are
// taken throughout.
`include "two_region_binned_mean_heatmap_assert.svh"
module two_region_binned_mean_heatmap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trbmh_in_if.sink    in_ch,
    trbmh_out_if.source out_ch,
    trbmh_cfg_if.sink   cfg_ch
);
    import trbmh_pkg::*;

    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = BIN_W + LVL_W;
    localparam int CELLS  = BIN_COUNT * LEVELS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BDIV  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_RMW   = 4'd4;
    localparam logic [3:0] S_MREAD = 4'd5;
    localparam logic [3:0] S_MDIV  = 4'd6;
    localparam logic [3:0] S_EDGE  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_MWAIT = 4'd9;

    // configuration registers
    logic [31:0] r_split_time, r_end_time, r_width1, r_width2;
    logic [6:0]  r_split_bin, r_bins_used;
    logic [5:0]  r_level_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_time <= '0;
            r_end_time   <= '0;
            r_width1     <= 32'd1;
            r_width2     <= 32'd1;
            r_split_bin  <= 7'd32;
            r_bins_used  <= 7'd64;
            r_level_max  <= 6'd63;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.data.index)
                CFG_SPLIT_TIME: r_split_time <= cfg_ch.data.data;
                CFG_END_TIME:   r_end_time   <= cfg_ch.data.data;
                CFG_WIDTH1:     r_width1     <= cfg_ch.data.data;
                CFG_WIDTH2:     r_width2     <= cfg_ch.data.data;
                CFG_SPLIT_BIN:  r_split_bin  <= cfg_ch.data.data[6:0];
                CFG_BINS_USED:  r_bins_used  <= cfg_ch.data.data[6:0];
                CFG_LEVEL_MAX:  r_level_max  <= cfg_ch.data.data[5:0];
                default: ;
            endcase
        end
    end
    assign cfg_ch.ready = 1'b1;

    logic [31:0] w_eff_w1, w_eff_w2;
    assign w_eff_w1 = (r_width1 == 32'd0) ? 32'd1 : r_width1;
    assign w_eff_w2 = (r_width2 == 32'd0) ? 32'd1 : r_width2;

    // sequencer state
    logic [3:0]        r_state, n_state;
    logic [ADDR_W:0]   r_clr, n_clr;
    t_in_word          r_word;
    logic              r_region2;
    logic [32:0]       r_bin;
    logic [ADDR_W-1:0] r_addr;
    logic              r_ingrid;
    logic [15:0]       r_cnt_hold;
    logic [31:0]       r_mean;
    logic [63:0]       r_edge_prod;
    logic [32:0]       r_edge_base;
    logic [31:0]       r_edge_sat;
    logic              r_ovalid;
    t_out_word         r_oword;

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    trbmh_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [31:0]       w_wsum, w_rsum;
    logic [15:0]       w_wcnt, w_rcnt;
    trbmh_cell_mem #(.ADDR_W(ADDR_W)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wsum(w_wsum),
        .i_wcnt(w_wcnt), .i_raddr(w_raddr), .o_rsum(w_rsum), .o_rcnt(w_rcnt)
    );

    logic w_accept;
    assign in_ch.ready = (r_state == S_IDLE);
    assign w_accept    = in_ch.valid && in_ch.ready;

    // grid test on a bin and a level
    function automatic logic grid_ok(input logic [32:0] b, input logic [5:0] l,
                                     input logic [6:0] used, input logic [5:0] lmax);
        grid_ok = (b < {26'd0, used}) && (b < 33'(BIN_COUNT))
                  && (l <= lmax) && ({26'd0, l} < 32'(LEVELS));
    endfunction

    logic [32:0] w_bin_calc;
    logic        w_grid_acc, w_grid_rd;
    logic [6:0]  w_rb_p1;
    logic        w_rb_low;
    assign w_bin_calc = r_region2 ? ({26'd0, r_split_bin} + {1'b0, w_drsp.quotient})
                                  : {1'b0, w_drsp.quotient};
    assign w_grid_acc = grid_ok(r_bin, r_word.level, r_bins_used, r_level_max);
    assign w_grid_rd  = grid_ok({27'd0, r_word.read_bin}, r_word.level,
                                r_bins_used, r_level_max);
    assign w_rb_low   = {1'b0, r_word.read_bin} < r_split_bin;
    assign w_rb_p1    = w_rb_low ? ({1'b0, r_word.read_bin} + 7'd1)
                                 : ({1'b0, r_word.read_bin} + 7'd1 - r_split_bin);

    logic [33:0] w_edge_sum;
    assign w_edge_sum = {1'b0, r_edge_base} + {1'b0, r_edge_prod[32:0]};

    // control and memory drive
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        w_dreq   = '0;
        w_we     = 1'b0;
        w_waddr  = r_addr;
        w_wsum   = w_rsum + {16'd0, r_word.abundance};
        w_wcnt   = w_rcnt + 16'd1;
        w_raddr  = r_addr;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr[ADDR_W-1:0];
                w_wsum  = '0;
                w_wcnt  = '0;
                n_clr   = r_clr + (ADDR_W+1)'(1);
                if (r_clr == (ADDR_W+1)'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (in_ch.data.req_type) begin
                        n_state = S_MREAD;
                    end else if (in_ch.data.sample_time > r_end_time) begin
                        n_state = S_OUT;
                    end else begin
                        w_dreq.start = 1'b1;
                        if (in_ch.data.sample_time < r_split_time) begin
                            w_dreq.dividend = in_ch.data.sample_time;
                            w_dreq.divisor  = w_eff_w1;
                        end else begin
                            w_dreq.dividend = in_ch.data.sample_time - r_split_time;
                            w_dreq.divisor  = w_eff_w2;
                        end
                        n_state = S_BDIV;
                    end
                end
            end
            S_BDIV:  if (w_drsp.done) n_state = S_CHECK;
            S_CHECK: n_state = w_grid_acc ? S_RMW : S_OUT;
            S_RMW: begin
                // memory data for r_addr is valid this cycle
                w_we    = (w_rcnt != 16'hFFFF);
                n_state = S_OUT;
            end
            S_MREAD: n_state = S_MWAIT;
            S_MWAIT: begin
                if (r_ingrid && w_rcnt != 16'd0) begin
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = w_rsum;
                    w_dreq.divisor  = {16'd0, w_rcnt};
                    n_state = S_MDIV;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_MDIV:  if (w_drsp.done) n_state = S_EDGE;
            S_EDGE:  n_state = S_OUT;
            S_OUT:   if (!r_ovalid || out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (r_state == S_OUT && (!r_ovalid || out_ch.ready)) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;
        end
        if (w_accept) begin
            r_word     <= in_ch.data;
            r_region2  <= !(in_ch.data.sample_time < r_split_time);
            r_mean     <= '0;
            r_cnt_hold <= '0;
            r_oword    <= r_oword;
            r_edge_prod <= '0;
            r_edge_base <= '0;
            r_ingrid   <= 1'b0;
            r_bin      <= '0;
            if (in_ch.data.req_type) begin
                r_addr <= ADDR_W'({in_ch.data.read_bin[BIN_W-1:0], in_ch.data.level[LVL_W-1:0]});
            end
        end
        if (r_state == S_BDIV && w_drsp.done) begin
            r_bin  <= w_bin_calc;
            r_addr <= ADDR_W'({w_bin_calc[BIN_W-1:0], r_word.level[LVL_W-1:0]});
        end
        if (r_state == S_MREAD) r_ingrid <= w_grid_rd;
        if (r_state == S_MWAIT) begin
            r_cnt_hold <= r_ingrid ? w_rcnt : 16'd0;
            // edge product, one 32x7 multiply
            r_edge_prod <= {32'd0, (w_rb_low ? w_eff_w1 : w_eff_w2)} * {57'd0, w_rb_p1};
            r_edge_base <= w_rb_low ? 33'd0 : {1'b0, r_split_time};
        end
        if (r_state == S_MDIV && w_drsp.done) r_mean <= w_drsp.quotient;
        // saturated edge, held until the output word is free
        if (r_state == S_EDGE) begin
            r_edge_sat <= (r_edge_prod[63:33] != '0 || w_edge_sum[33:32] != 2'd0)
                          ? 32'hFFFF_FFFF : w_edge_sum[31:0];
        end
        if (r_state == S_OUT && (!r_ovalid || out_ch.ready)) begin
            r_oword.mean_value <= (r_mean > 32'h0000_FFFF) ? 16'hFFFF : r_mean[15:0];
            r_oword.cell_count <= r_cnt_hold;
            if (r_word.req_type) begin
                r_oword.status   <= ST_READ;
                r_oword.bin_edge <= r_edge_sat;
            end else begin
                r_oword.bin_edge <= '0;
                if (r_word.sample_time > r_end_time) r_oword.status <= ST_LATE;
                else if (!grid_ok(r_bin, r_word.level, r_bins_used, r_level_max))
                    r_oword.status <= ST_OUT;
                else r_oword.status <= ST_ACC;
            end
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_oword;

    // checks
    `TRBMH_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !in_ch.ready,
        "word accepted while busy")
    `TRBMH_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.data), "result dropped under stall")
    `TRBMH_ASSERT_IMP(a_wr_only_rmw, i_clk, i_rst_n, w_we,
        r_state == S_CLEAR || r_state == S_RMW, "cell write outside update")
endmodule

// File: sim/tb_if.sv
// Testbench note: the channel interfaces come from rtl/trbmh_if.sv; this file holds the shared clock period.
`timescale 1ns / 100ps
package tb_timing_pkg;
    localparam int CLK_PERIOD = 12;
endpackage

// File: sim/tb.sv
// Testbench for the binned mean heatmap: directed table, extreme settings, then random words, checked by a predictor
`timescale 1ns / 100ps
module tb;
    import trbmh_pkg::*;
    import tb_timing_pkg::*;

    localparam int NBINS = 64;
    localparam int NLVL  = 64;
    localparam int LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    trbmh_in_if  in_ch ();
    trbmh_out_if out_ch ();
    trbmh_cfg_if cfg_ch ();

    two_region_binned_mean_heatmap DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    // predictor copy of the registers and cell store
    logic [31:0] m_split_time, m_end_time, m_w1, m_w2;
    logic [6:0]  m_split_bin, m_bins_used;
    logic [5:0]  m_level_max;
    logic [31:0] m_sum [NBINS*NLVL];
    logic [15:0] m_tally [NBINS*NLVL];

    t_out_word expected_words[$];
    int errors = 0;
    int send_idle = 10, recv_idle = 51;
    bit hold_recv = 0;
    int cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] eff(input logic [31:0] w);
        return (w == 0) ? 64'd1 : {32'd0, w};
    endfunction

    function automatic bit grid_ok(input logic [63:0] bin, input logic [5:0] lvl);
        return bin < m_bins_used && bin < NBINS && lvl <= m_level_max;
    endfunction

    // compute the result word of one request and update the cell store
    function automatic t_out_word heatmap_step(input t_in_word w);
        t_out_word r;
        logic [63:0] bin, e;
        int idx;
        r = '0;
        if (!w.req_type) begin
            if (w.sample_time > m_end_time) r.status = ST_LATE;
            else begin
                if (w.sample_time < m_split_time) bin = w.sample_time / eff(m_w1);
                else bin = m_split_bin + (w.sample_time - m_split_time) / eff(m_w2);
                if (!grid_ok(bin, w.level)) r.status = ST_OUT;
                else begin
                    r.status = ST_ACC;
                    idx = int'(bin) * NLVL + w.level;
                    if (m_tally[idx] != 16'hFFFF) begin
                        m_sum[idx] += w.abundance;
                        m_tally[idx] += 1;
                    end
                end
            end
        end else begin
            r.status = ST_READ;
            if (grid_ok({58'd0, w.read_bin}, w.level)) begin
                idx = w.read_bin * NLVL + w.level;
                r.cell_count = m_tally[idx];
                if (m_tally[idx] != 0) begin
                    e = m_sum[idx] / m_tally[idx];
                    r.mean_value = (e > 64'hFFFF) ? 16'hFFFF : e[15:0];
                end
            end
            if (w.read_bin < m_split_bin) e = (w.read_bin + 64'd1) * eff(m_w1);
            else e = m_split_time + ((w.read_bin - m_split_bin) + 64'd1) * eff(m_w2);
            r.bin_edge = (e > 64'hFFFFFFFF) ? 32'hFFFFFFFF : e[31:0];
        end
        return r;
    endfunction

    // write one register and mirror it; valid stays up for the next write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SPLIT_TIME: m_split_time = val;
            CFG_END_TIME:   m_end_time = val;
            CFG_WIDTH1:     m_w1 = val;
            CFG_WIDTH2:     m_w2 = val;
            CFG_SPLIT_BIN:  m_split_bin = val[6:0];
            CFG_BINS_USED:  m_bins_used = val[6:0];
            CFG_LEVEL_MAX:  m_level_max = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] st, et, w1, w2, input int sb, bu, lm);
        write_reg(CFG_SPLIT_TIME, st);
        write_reg(CFG_END_TIME, et);
        write_reg(CFG_WIDTH1, w1);
        write_reg(CFG_WIDTH2, w2);
        write_reg(CFG_SPLIT_BIN, sb);
        write_reg(CFG_BINS_USED, bu);
        write_reg(CFG_LEVEL_MAX, lm);
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one word; expectation is pushed at acceptance
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_words.push_back(heatmap_step(w));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_word rand_word(input int ptime);
        t_in_word w;
        w.req_type = ($urandom_range(99) < 30);
        case ($urandom_range(3))
            0: w.sample_time = $urandom;
            default: w.sample_time = $urandom_range(ptime);
        endcase
        w.level = $urandom_range(99) < 80 ? 6'($urandom_range(7)) : 6'($urandom);
        w.abundance = 16'($urandom);
        w.read_bin = $urandom_range(99) < 70 ? 6'($urandom_range(15)) : 6'($urandom);
        return w;
    endfunction

    // response side: random stall, checked on acceptance
    always @(posedge i_clk) begin
        t_out_word got, want;
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_words.size() == 0) report("unexpected word", got.status, 0);
                else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status) report("status", got.status, want.status);
                    if (got.mean_value !== want.mean_value)
                        report("mean_value", got.mean_value, want.mean_value);
                    if (got.cell_count !== want.cell_count)
                        report("cell_count", got.cell_count, want.cell_count);
                    if (got.bin_edge !== want.bin_edge)
                        report("bin_edge", got.bin_edge, want.bin_edge);
                end
            end
            out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word r;
    } t_row;

    initial begin
        t_row rows[$];
        t_in_word w;
        int p;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        m_split_time = 0; m_end_time = 0; m_w1 = 1; m_w2 = 1;
        m_split_bin = 32; m_bins_used = 64; m_level_max = 63;
        for (int i = 0; i < NBINS*NLVL; i++) begin
            m_sum[i] = 0;
            m_tally[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; reset registers put t = 0 in bin 32, all widths 1
        rows.push_back('{'{1, 0, 0, 0, 0}, 1, '{ST_READ, 0, 0, 1}});
        rows.push_back('{'{1, 0, 63, 0, 63}, 1, '{ST_READ, 0, 0, 32}});
        rows.push_back('{'{0, 1, 0, 0, 0}, 1, '{ST_LATE, 0, 0, 0}});
        rows.push_back('{'{0, 32'hFFFFFFFF, 0, 0, 0}, 1, '{ST_LATE, 0, 0, 0}});
        rows.push_back('{'{0, 0, 0, 16'hFFFF, 0}, 0, '0});
        rows.push_back('{'{0, 0, 63, 16'h0001, 0}, 0, '0});
        rows.push_back('{'{0, 0, 0, 16'hFFFF, 0}, 0, '0});
        rows.push_back('{'{1, 0, 0, 0, 32}, 1, '{ST_READ, 16'hFFFF, 2, 32'h1}});
        rows.push_back('{'{1, 0, 63, 0, 32}, 1, '{ST_READ, 1, 1, 32'h1}});
        foreach (rows[i]) begin
            t_out_word pr;
            send_word(rows[i].w);
            pr = expected_words[$];
            if (rows[i].typed && pr !== rows[i].r) report("table row", i, pr.status);
        end
        drain();

        // wide grid, extreme widths and split
        set_all(32'd1000, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 64, 64, 63);
        rows = {};
        rows.push_back('{'{0, 32'hFFFFFFFF, 63, 16'h1234, 0}, 0, '0});
        rows.push_back('{'{1, 0, 63, 0, 63}, 0, '0});
        rows.push_back('{'{1, 0, 63, 0, 0}, 0, '0});
        foreach (rows[i]) send_word(rows[i].w);
        drain();
        set_all(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 0);
        send_word('{0, 5, 0, 7, 0});
        send_word('{0, 5, 1, 7, 0});
        send_word('{1, 0, 0, 0, 63});
        send_word('{1, 0, 1, 0, 0});
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin send_idle = 51; recv_idle = 10; end
            if (ph == 6) begin send_idle = 0; recv_idle = 0; end
            p = $urandom_range(1, 4000);
            set_all($urandom_range(p), $urandom_range(p/2, p), $urandom_range(0, 200),
                    $urandom_range(0, 200), $urandom_range(0, 64), $urandom_range(1, 64),
                    $urandom_range(0, 63));
            if (ph == 2) begin
                fork
                    begin hold_recv = 1; repeat (600) @(posedge i_clk); hold_recv = 0; end
                join_none
            end
            for (int k = 0; k < 200; k++) send_word(rand_word(p));
            drain();
        end

        if (errors == 0 && expected_words.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/trbmh_pkg.sv
rtl/trbmh_if.sv
rtl/trbmh_div.sv
rtl/trbmh_cell_mem.sv
rtl/two_region_binned_mean_heatmap.sv
sim/tb_if.sv
sim/tb.sv
